[hw/rtl/skew_monomial_sign_assert.svh]
// Assertion helpers for the monomial sign block.
// Both forms sample on aclk and stay quiet while aresetn is low.
`ifndef SKEW_MONOMIAL_SIGN_ASSERT_SVH
`define SKEW_MONOMIAL_SIGN_ASSERT_SVH

// Same-cycle implication.
`define SMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sms_pkg.sv]
`default_nettype none

package sms_pkg;

    // Operation codes carried on the first request of a vector
    typedef enum logic [1:0] {
        OP_PRODUCT = 2'd0,
        OP_DIVIDE  = 2'd1,
        OP_DIFF    = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    // Fixed field widths
    localparam int unsigned EXP_W   = 16;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned MASK_W  = 64;

    // Signed sign-field encodings
    localparam logic signed [1:0] SIGN_ZERO = 2'sd0;
    localparam logic signed [1:0] SIGN_POS  = 2'sd1;
    localparam logic signed [1:0] SIGN_NEG  = -2'sd1;

endpackage

`default_nettype wire

[hw/rtl/skew_monomial_sign.sv]
// An accepted request's result is registered and shows on the m_ side in the next cycle.
// Throughput: one request per cycle; s_ready stays high while the result
// register is empty or being drained, so the single output register sets the rate.
// Reset (aresetn low, synchronous): clears skew_mask, the per-vector running
// state and the result valid; result payload registers are not reset.
`default_nettype none

`include "skew_monomial_sign_assert.svh"

module skew_monomial_sign #(
    parameter int MAX_VARS = 64,
    parameter int EXP_BITS = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               cfg_wr_en,
    input  wire  [sms_pkg::MASK_W-1:0]        cfg_wr_data,

    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [1:0]                        s_op,
    input  wire  [sms_pkg::EXP_W-1:0]         s_exp_a,
    input  wire  [sms_pkg::EXP_W-1:0]         s_exp_b,
    input  wire                               s_last,

    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [sms_pkg::EXP_W-1:0]         m_result_exp,
    output logic                              m_exp_valid,
    output logic signed [1:0]                 m_sign,
    output logic [sms_pkg::COUNT_W-1:0]       m_skew_count,
    output logic                              m_has_square,
    output logic                              m_end_flag
);

    // Effective exponent width after wrapping to EXP_BITS
    localparam int EW = (EXP_BITS < int'(sms_pkg::EXP_W)) ? EXP_BITS : int'(sms_pkg::EXP_W);
    // Position counter saturates at MAX_VARS
    localparam int PW = $clog2(MAX_VARS + 1);

    logic [sms_pkg::MASK_W-1:0]  skew_mask_reg;
    logic [PW-1:0]               pos_reg, pos_next;
    sms_pkg::op_t                op_reg, op_next;
    logic                        left_reg, left_next;
    logic                        inv_reg, inv_next;
    logic                        clash_reg, clash_next;
    logic [sms_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                        sq_reg, sq_next;

    logic                        out_valid_reg;
    logic [sms_pkg::EXP_W-1:0]   res_exp_reg, res_exp_next;
    logic                        exp_ok_reg, exp_ok_next;
    logic signed [1:0]           sign_reg, sign_next;
    logic [sms_pkg::COUNT_W-1:0] cnt_out_reg, cnt_out_next;
    logic                        sq_out_reg, sq_out_next;
    logic                        end_reg;

    logic                        accept;
    sms_pkg::op_t                op_cur;
    logic [6:0]                  pos_ext;
    logic                        skew;
    logic [EW-1:0]               ea, eb;
    logic [EW:0]                 diff_ab, diff_ba;
    logic [EW-1:0]               diff;
    logic                        ok;
    logic                        in1, in2;
    logic                        neg;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Per-variable update of the running parity state
    always_comb begin
        op_cur = (pos_reg == '0) ? sms_pkg::op_t'(s_op) : op_reg;
        if (op_cur == sms_pkg::OP_SPARE) begin
            op_cur = sms_pkg::OP_PRODUCT;
        end

        pos_ext = 7'(pos_reg);
        skew    = (pos_reg < PW'(MAX_VARS)) && skew_mask_reg[pos_ext[5:0]];

        ea      = s_exp_a[EW-1:0];
        eb      = s_exp_b[EW-1:0];
        diff_ab = {1'b0, ea} - {1'b0, eb};
        diff_ba = {1'b0, eb} - {1'b0, ea};

        unique case (op_cur)
            sms_pkg::OP_DIVIDE: begin
                ok   = !diff_ab[EW];
                diff = ok ? diff_ab[EW-1:0] : '0;
                in1  = ok && (diff != '0);
                in2  = (eb != '0);
            end
            sms_pkg::OP_DIFF: begin
                ok   = !diff_ba[EW];
                diff = ok ? diff_ba[EW-1:0] : '0;
                in1  = ok && (diff != '0);
                in2  = (ea != '0);
            end
            default: begin
                ok   = 1'b1;
                diff = '0;
                in1  = (ea != '0);
                in2  = (eb != '0);
            end
        endcase

        clash_next = clash_reg || !ok || (skew && in1 && in2);
        inv_next   = inv_reg ^ (skew && in1 && left_reg);
        left_next  = left_reg ^ (skew && in2);
        cnt_next   = (skew && ea != '0) ? cnt_reg + 7'd1 : cnt_reg;
        sq_next    = sq_reg || (skew && ea > EW'(1));
        op_next    = op_cur;
        pos_next   = (pos_reg < PW'(MAX_VARS)) ? pos_reg + PW'(1) : pos_reg;

        // Final sign, flipped for diff when the skew degree mod 4 is 2 or 3
        neg = inv_next ^ ((op_cur == sms_pkg::OP_DIFF) && cnt_next[1]);

        res_exp_next = sms_pkg::EXP_W'(diff);
        exp_ok_next  = ok;
        if (s_last) begin
            sign_next    = clash_next ? sms_pkg::SIGN_ZERO :
                           (neg ? sms_pkg::SIGN_NEG : sms_pkg::SIGN_POS);
            cnt_out_next = cnt_next;
            sq_out_next  = sq_next;
        end else begin
            sign_next    = sms_pkg::SIGN_ZERO;
            cnt_out_next = '0;
            sq_out_next  = 1'b0;
        end
    end

    // Load the skew mask on a config write; hold running state, clear it after the final request of a vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skew_mask_reg <= '0;
            pos_reg       <= '0;
            op_reg        <= sms_pkg::OP_PRODUCT;
            left_reg      <= 1'b0;
            inv_reg       <= 1'b0;
            clash_reg     <= 1'b0;
            cnt_reg       <= '0;
            sq_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                skew_mask_reg <= cfg_wr_data;
            end
            if (accept) begin
                if (s_last) begin
                    pos_reg   <= '0;
                    op_reg    <= sms_pkg::OP_PRODUCT;
                    left_reg  <= 1'b0;
                    inv_reg   <= 1'b0;
                    clash_reg <= 1'b0;
                    cnt_reg   <= '0;
                    sq_reg    <= 1'b0;
                end else begin
                    pos_reg   <= pos_next;
                    op_reg    <= op_next;
                    left_reg  <= left_next;
                    inv_reg   <= inv_next;
                    clash_reg <= clash_next;
                    cnt_reg   <= cnt_next;
                    sq_reg    <= sq_next;
                end
            end
        end
    end

    // Result valid: set on accept, drop when drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_exp_reg <= res_exp_next;
            exp_ok_reg  <= exp_ok_next;
            sign_reg    <= sign_next;
            cnt_out_reg <= cnt_out_next;
            sq_out_reg  <= sq_out_next;
            end_reg     <= s_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_result_exp = res_exp_reg;
    assign m_exp_valid  = exp_ok_reg;
    assign m_sign       = sign_reg;
    assign m_skew_count = cnt_out_reg;
    assign m_has_square = sq_out_reg;
    assign m_end_flag   = end_reg;

    `SMS_ASSERT_NOW(a_mid_fields_zero, m_valid && !m_end_flag,
        m_sign == sms_pkg::SIGN_ZERO && m_skew_count == '0 && !m_has_square,
        "summary fields set on a non-final result")
    `SMS_ASSERT_NOW(a_neg_diff_zero, m_valid && !m_exp_valid, m_result_exp == '0,
        "negative difference left a nonzero exponent")
    `SMS_ASSERT_NOW(a_neg_diff_sign, m_valid && m_end_flag && !m_exp_valid,
        m_sign == sms_pkg::SIGN_ZERO, "negative difference did not zero the sign")
    `SMS_ASSERT_NEXT(a_clear_after_last, accept && s_last,
        pos_reg == '0 && !clash_reg && !inv_reg && !left_reg && cnt_reg == '0 && !sq_reg,
        "vector state not cleared after final request")
    `SMS_ASSERT_NOW(a_pos_saturates, 1'b1, pos_reg <= PW'(MAX_VARS),
        "position ran past its limit")

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_VARS = 64;

    // One request: one variable of the two exponent vectors
    typedef struct {
        sms_pkg::op_t op;
        logic [15:0]  exp_a;
        logic [15:0]  exp_b;
        logic         last;
        logic         drain_first;
    } var_req_t;

    // One result as the block reports it
    typedef struct {
        logic [15:0]       result_exp;
        logic              exp_valid;
        logic signed [1:0] sign;
        logic [6:0]        skew_count;
        logic              has_square;
        logic              end_flag;
    } var_result_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op        = '0;
    logic [15:0] s_exp_a     = '0;
    logic [15:0] s_exp_b     = '0;
    logic        s_last      = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [15:0] m_result_exp;
    logic        m_exp_valid;
    logic signed [1:0] m_sign;
    logic [6:0]  m_skew_count;
    logic        m_has_square;
    logic        m_end_flag;

    skew_monomial_sign #(
        .MAX_VARS (MAX_VARS),
        .EXP_BITS (16)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_exp_a      (s_exp_a),
        .s_exp_b      (s_exp_b),
        .s_last       (s_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_exp (m_result_exp),
        .m_exp_valid  (m_exp_valid),
        .m_sign       (m_sign),
        .m_skew_count (m_skew_count),
        .m_has_square (m_has_square),
        .m_end_flag   (m_end_flag)
    );

    var_req_t    queued_vars[$];
    var_result_t pending_results[$];
    var_req_t    cur_req;
    var_result_t want;
    int          n_requests = 0;
    int          n_results  = 0;
    int          n_fail     = 0;
    int          n_vectors  = 0;
    int          n_masks    = 0;
    bit          steady     = 1'b0;

    // Mirror of the mask register and the per-vector running state
    logic [63:0]  skew_map  = '0;
    logic [6:0]   vec_pos   = '0;
    sms_pkg::op_t vec_op    = sms_pkg::OP_PRODUCT;
    logic         left_par  = 1'b0;
    logic         inv_par   = 1'b0;
    logic         zero_sign = 1'b0;
    logic [6:0]   a_skew_n  = '0;
    logic         a_square  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report(string what);
        n_fail++;
        if (n_fail <= 40) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
    endtask

    // Fold one variable into the running sign state and return its result
    function automatic var_result_t monomial_sign_step(var_req_t r);
        var_result_t  o;
        sms_pkg::op_t eff;
        logic         is_skew;
        logic         in_first;
        logic         in_second;
        logic [15:0]  d;
        logic         ok;
        o = '{default: '0};
        if (vec_pos == 0) vec_op = r.op;
        eff = (vec_op == sms_pkg::OP_SPARE) ? sms_pkg::OP_PRODUCT : vec_op;
        is_skew = (vec_pos < MAX_VARS) && skew_map[vec_pos[5:0]];
        d = '0;
        ok = 1'b1;
        case (eff)
            sms_pkg::OP_DIVIDE: begin
                if (r.exp_a >= r.exp_b) d = r.exp_a - r.exp_b;
                else ok = 1'b0;
            end
            sms_pkg::OP_DIFF: begin
                if (r.exp_b >= r.exp_a) d = r.exp_b - r.exp_a;
                else ok = 1'b0;
            end
            default: ;
        endcase
        if (!ok) zero_sign = 1'b1;
        in_first = 1'b0;
        in_second = 1'b0;
        if (is_skew) begin
            if (r.exp_a != 0) begin
                a_skew_n++;
                if (r.exp_a >= 2) a_square = 1'b1;
            end
            case (eff)
                sms_pkg::OP_PRODUCT: begin
                    in_first  = r.exp_a != 0;
                    in_second = r.exp_b != 0;
                end
                sms_pkg::OP_DIVIDE: begin
                    in_first  = ok && d != 0;
                    in_second = r.exp_b != 0;
                end
                default: begin
                    in_first  = ok && d != 0;
                    in_second = r.exp_a != 0;
                end
            endcase
            // A shared skew variable kills the product
            if (in_first && in_second) zero_sign = 1'b1;
            if (in_first) inv_par ^= left_par;
            if (in_second) left_par ^= 1'b1;
        end
        o.result_exp = d;
        o.exp_valid = ok;
        o.end_flag = r.last;
        if (r.last) begin
            if (zero_sign) begin
                o.sign = sms_pkg::SIGN_ZERO;
            end else begin
                o.sign = inv_par ? sms_pkg::SIGN_NEG : sms_pkg::SIGN_POS;
                // Degree 2 or 3 mod 4 flips the derivative sign
                if (eff == sms_pkg::OP_DIFF && a_skew_n[1])
                    o.sign = (o.sign == sms_pkg::SIGN_POS) ? sms_pkg::SIGN_NEG
                                                           : sms_pkg::SIGN_POS;
            end
            o.skew_count = a_skew_n;
            o.has_square = a_square;
            vec_pos = '0;
            vec_op = sms_pkg::OP_PRODUCT;
            left_par = 1'b0;
            inv_par = 1'b0;
            zero_sign = 1'b0;
            a_skew_n = '0;
            a_square = 1'b0;
        end else if (vec_pos < MAX_VARS) begin
            vec_pos++;
        end
        return o;
    endfunction

    // Driver: present queued requests, idle at random, hold until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(monomial_sign_step(cur_req));
                n_requests++;
            end
            if (!s_valid || s_ready) begin
                if (queued_vars.size() != 0
                        && !(!steady && $urandom_range(0, 99) < 36)
                        && !(queued_vars[0].drain_first && n_requests != n_results)) begin
                    cur_req = queued_vars.pop_front();
                    s_valid <= 1'b1;
                    s_op    <= cur_req.op;
                    s_exp_a <= cur_req.exp_a;
                    s_exp_b <= cur_req.exp_b;
                    s_last  <= cur_req.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results <= n_results + 1;
            if (pending_results.size() == 0) begin
                report("result arrived with nothing predicted");
            end else begin
                want = pending_results.pop_front();
                if (m_result_exp !== want.result_exp)
                    report($sformatf("result_exp got %0d want %0d",
                                     m_result_exp, want.result_exp));
                if (m_exp_valid !== want.exp_valid)
                    report($sformatf("exp_valid got %b want %b", m_exp_valid, want.exp_valid));
                if (m_sign !== want.sign)
                    report($sformatf("sign got %0d want %0d", m_sign, want.sign));
                if (m_skew_count !== want.skew_count)
                    report($sformatf("skew_count got %0d want %0d",
                                     m_skew_count, want.skew_count));
                if (m_has_square !== want.has_square)
                    report($sformatf("has_square got %b want %b",
                                     m_has_square, want.has_square));
                if (m_end_flag !== want.end_flag)
                    report($sformatf("end_flag got %b want %b", m_end_flag, want.end_flag));
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    function automatic logic [15:0] pick_exp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'd0;
            4, 5:       return 16'd1;
            6:          return 16'd2;
            7:          return 16'($urandom_range(3, 15));
            8:          return $urandom_range(0, 1) ? 16'hFFFF : 16'hFFFE;
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic push_request(sms_pkg::op_t op, logic [15:0] a, logic [15:0] b,
                                logic last, logic drain);
        var_req_t r;
        r.op = op;
        r.exp_a = a;
        r.exp_b = b;
        r.last = last;
        r.drain_first = drain;
        queued_vars.push_back(r);
    endtask

    // Build one vector; a clean one keeps differences non-negative and
    // the two skew sets disjoint so the sign survives to the end
    task automatic gen_vector(int nvars, bit clean);
        sms_pkg::op_t vop;
        logic [15:0]  x;
        logic [15:0]  a;
        logic [15:0]  b;
        bit           skew;
        int           pick;
        pick = $urandom_range(0, 19);
        vop = (pick == 0) ? sms_pkg::OP_SPARE : sms_pkg::op_t'(pick % 3);
        n_vectors++;
        for (int j = 0; j < nvars; j++) begin
            x = pick_exp();
            skew = (j < MAX_VARS) && skew_map[j % 64];
            if (!clean) begin
                a = pick_exp();
                b = pick_exp();
            end else begin
                case (vop)
                    sms_pkg::OP_DIVIDE: begin
                        a = x;
                        if (skew) b = $urandom_range(0, 1) ? x : 16'd0;
                        else b = 16'($urandom_range(0, x));
                    end
                    sms_pkg::OP_DIFF: begin
                        b = x;
                        if (skew) a = $urandom_range(0, 1) ? x : 16'd0;
                        else a = 16'($urandom_range(0, x));
                    end
                    default: begin
                        if (!skew) begin
                            a = x;
                            b = pick_exp();
                        end else begin
                            case ($urandom_range(0, 2))
                                0:       begin a = x;     b = 16'd0; end
                                1:       begin a = 16'd0; b = x;     end
                                default: begin a = 16'd0; b = 16'd0; end
                            endcase
                        end
                    end
                endcase
            end
            // Only the first op of a vector counts; scramble the rest
            push_request((j == 0) ? vop : sms_pkg::op_t'($urandom_range(0, 3)), a, b,
                         j == nvars - 1, $urandom_range(0, 299) == 0);
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (queued_vars.size() != 0 || s_valid || pending_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_mask(logic [63:0] m);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        skew_map = m;
        n_masks++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stimulus: directed vectors, then random phases under several masks
    initial begin
        logic [63:0] m;
        int          len;
        int          budget;
        int          guard;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        load_mask('1);
        push_request(sms_pkg::OP_PRODUCT, 16'd0, 16'd0, 1'b1, 1'b0);
        // Product with one inversion
        push_request(sms_pkg::OP_PRODUCT, 16'd1, 16'd0, 1'b0, 1'b0);
        push_request(sms_pkg::OP_SPARE,   16'd0, 16'd1, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIFF,    16'd1, 16'd0, 1'b1, 1'b0);
        // Shared skew variable, then extreme exponents
        push_request(sms_pkg::OP_PRODUCT, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        push_request(sms_pkg::OP_PRODUCT, 16'hFFFF, 16'd0, 1'b0, 1'b0);
        push_request(sms_pkg::OP_PRODUCT, 16'd0, 16'hFFFF, 1'b1, 1'b0);
        // Divide with a negative difference; hold mid-vector until drained
        push_request(sms_pkg::OP_DIVIDE, 16'd5, 16'd2, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIVIDE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
        push_request(sms_pkg::OP_DIVIDE, 16'd0, 16'd1, 1'b1, 1'b0);
        push_request(sms_pkg::OP_DIVIDE, 16'd3, 16'd0, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIVIDE, 16'd2, 16'd2, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIVIDE, 16'd0, 16'd0, 1'b1, 1'b0);
        // Derivative with degree two, then a negative one
        push_request(sms_pkg::OP_DIFF, 16'd1, 16'd1, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIFF, 16'd1, 16'd1, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIFF, 16'd0, 16'hFFFF, 1'b1, 1'b0);
        push_request(sms_pkg::OP_DIFF, 16'd2, 16'd1, 1'b1, 1'b0);
        // Spare op acts as a product
        push_request(sms_pkg::OP_SPARE, 16'd1, 16'd0, 1'b0, 1'b0);
        push_request(sms_pkg::OP_DIVIDE, 16'd0, 16'd1, 1'b1, 1'b0);
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       m = '0;
                1:       m = '1;
                2:       m = 64'hAAAA_AAAA_AAAA_AAAA;
                3:       m = 64'h8000_0000_0000_0001;
                4:       m = {$urandom, $urandom};
                5:       m = {$urandom, $urandom} & {$urandom, $urandom};
                default: m = {$urandom, $urandom} | {$urandom, $urandom};
            endcase
            load_mask(m);
            steady = (p == 2);
            budget = 0;
            // Run past the last tracked variable now and then
            if (p % 2 == 0) begin
                len = $urandom_range(64, 72);
                gen_vector(len, 1'b1);
                budget += len;
            end
            while (budget < 165) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                gen_vector(len, $urandom_range(0, 9) < 7);
                budget += len;
            end
            if (p != 6) wait_idle();
        end

        // Drain, then allow the output register to settle
        while (queued_vars.size() != 0 || s_valid) @(negedge aclk);
        guard = 0;
        while (pending_results.size() != 0 && guard < 5000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));

        $display("Run covered %0d requests in %0d vectors under %0d mask settings,",
                 n_requests, n_vectors, n_masks);
        $display("all four op codes, negative differences, clashes and overlong vectors.");
        if (n_fail == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
